[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL modules of the circumcircle block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs across reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the triangle circumcircle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    // Width of each result field on the output beat.
    localparam int OUT_W    = 32;
    localparam int M_DATA_W = 3 * OUT_W;

    // Pipeline step control handed to the arithmetic sections.
    typedef struct packed {
        logic adv;   // whole pipeline moves one stage
        logic vld;   // item present at the section input
    } step_t;

endpackage

`default_nettype wire

[hw/rtl/tcc_sqrt.sv]
// ----------------------------------------------------------------------------
// tcc_sqrt
// Pipelined integer square root, one result bit per stage, with a side
// payload that travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcc_sqrt #(
    parameter int ROOT_W = 51,
    parameter int SIDE_W = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tcc_pkg::step_t        ctl,
    input  wire logic [2*ROOT_W-1:0]   rad,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       valid_out,
    output logic [ROOT_W-1:0]          root,
    output logic [SIDE_W-1:0]          side_out
);

    localparam int REM_W = ROOT_W + 2;
    localparam int T_W   = REM_W + 2;
    localparam int X_W   = 2 * ROOT_W;
    localparam int LAST  = ROOT_W - 1;

    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [X_W-1:0]    x_reg    [ROOT_W-1];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              vld_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [X_W-1:0]    x_in;
        logic [SIDE_W-1:0] side_in_k;
        logic [T_W-1:0]    trial;
        logic [T_W-1:0]    t_val;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign vld_in    = ctl.vld;
            assign rem_in    = '0;
            assign root_in   = '0;
            assign x_in      = rad;
            assign side_in_k = side_in;
        end else begin : g_chain
            assign vld_in    = vld_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign root_in   = root_reg[k-1];
            assign x_in      = x_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit
        always_comb begin
            t_val     = {rem_in, x_in[X_W-1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            ge        = (t_val >= trial);
            rem_next  = ge ? REM_W'(t_val - trial) : t_val[REM_W-1:0];
            root_next = {root_in[ROOT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ctl.adv) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.adv) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in_k;
            end
        end

        // Shift the radicand for all but the final stage
        if (k < LAST) begin : g_shift
            always_ff @(posedge aclk) begin
                if (ctl.adv) begin
                    x_reg[k] <= {x_in[X_W-3:0], 2'b00};
                end
            end
        end
    end

    assign valid_out = vld_reg[LAST];
    assign root      = root_reg[LAST];
    assign side_out  = side_reg[LAST];

    // Final remainder never exceeds twice the root
    `ASSERT_CLK(a_sqrt_rem_bound, aclk, aresetn,
        vld_reg[LAST] |-> rem_reg[LAST] <= (REM_W'(root_reg[LAST]) << 1),
        "sqrt remainder out of range")

endmodule

`default_nettype wire

[hw/rtl/tcc_div.sv]
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined restoring divider, one quotient bit per stage, several
// numerators sharing one divisor, with a side payload per item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcc_div #(
    parameter int NUM_W  = 53,
    parameter int DEN_W  = 35,
    parameter int LANES  = 3,
    parameter int SIDE_W = 3
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tcc_pkg::step_t                ctl,
    input  wire logic [LANES-1:0][NUM_W-1:0]   num,
    input  wire logic [DEN_W-1:0]              den,
    input  wire logic [SIDE_W-1:0]             side_in,
    output logic                               valid_out,
    output logic [LANES-1:0][NUM_W-1:0]        quo,
    output logic [SIDE_W-1:0]                  side_out
);

    localparam int LAST = NUM_W - 1;

    logic              vld_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W][LANES];
    logic [NUM_W-1:0]  nq_reg   [NUM_W][LANES];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              vld_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in_k;

        if (k == 0) begin : g_first
            assign vld_in    = ctl.vld;
            assign den_in    = den;
            assign side_in_k = side_in;
        end else begin : g_chain
            assign vld_in    = vld_reg[k-1];
            assign den_in    = den_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ctl.adv) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.adv) begin
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in_k;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W-1:0] rem_in;
            logic [NUM_W-1:0] nq_in;
            logic [DEN_W:0]   t_val;
            logic             ge;
            logic [DEN_W-1:0] rem_next;
            logic [NUM_W-1:0] nq_next;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign nq_in  = num[l];
            end else begin : g_chain
                assign rem_in = rem_reg[k-1][l];
                assign nq_in  = nq_reg[k-1][l];
            end

            // Shift in the next numerator bit, subtract the divisor if it fits
            always_comb begin
                t_val    = {rem_in, nq_in[NUM_W-1]};
                ge       = (t_val >= {1'b0, den_in});
                rem_next = ge ? DEN_W'(t_val - {1'b0, den_in}) : t_val[DEN_W-1:0];
                nq_next  = {nq_in[NUM_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (ctl.adv) begin
                    rem_reg[k][l] <= rem_next;
                    nq_reg[k][l]  <= nq_next;
                end
            end
        end
    end

    // Quotients leave from the last stage
    for (genvar l = 0; l < LANES; l++) begin : g_quo
        assign quo[l] = nq_reg[LAST][l];
    end

    assign valid_out = vld_reg[LAST];
    assign side_out  = side_reg[LAST];

    // Lane 0 remainder stays below a nonzero divisor
    `ASSERT_CLK(a_div_rem_bound, aclk, aresetn,
        vld_reg[LAST] && den_reg[LAST] != '0 |-> rem_reg[LAST][0] < den_reg[LAST],
        "divider remainder not below divisor")

endmodule

`default_nettype wire

[hw/rtl/triangle_circumcircle.sv]
// ----------------------------------------------------------------------------
// triangle_circumcircle
// Circumcenter and circumradius of a 2-D triangle in signed fixed point.
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle; the bit-serial root and divider stages
// are fully pipelined, one bit per stage, so nothing recirculates.
// A stall on m_axis_tready freezes every stage; s_axis_tready follows it.
// Reset (aresetn low, synchronous) clears all valid bits and drops any
// triangles in flight; data registers keep their contents.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module triangle_circumcircle #(
    parameter int COORD_WIDTH = 16,
    localparam int S_DATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // tdata: vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [S_DATA_W-1:0]            s_axis_tdata,
    // tdata: center_x, center_y, radius
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [tcc_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // tuser: degenerate
    output logic [0:0]                          m_axis_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;
    localparam int SQW    = 2 * W;
    localparam int SW     = 2 * W + 1;
    localparam int PXW    = 2 * DW;
    localparam int AW     = 2 * W + 3;
    localparam int TAW    = AW + 1;
    localparam int PW     = 3 * W + 3;
    localparam int TXW    = TAW + W;
    localparam int UW     = 3 * W + 4;
    localparam int NW     = 3 * W + 5;
    localparam int DEN_W  = TAW - 1;
    localparam int MW     = UW - 1;
    localparam int LO     = MW / 2;
    localparam int HI     = MW - LO;
    localparam int HH     = 2 * HI;
    localparam int HL     = HI + LO;
    localparam int LL     = 2 * LO;
    localparam int QW     = 2 * MW;
    localparam int FLAG_W = 3;
    localparam int SIDE_W = 2 * NW + DEN_W + FLAG_W;
    localparam int CW     = (NW > 33) ? NW : 33;
    localparam int OUT_W  = tcc_pkg::OUT_W;
    localparam int FRONT  = 9;

    localparam logic [CW-1:0] POS_MAX = CW'(33'h0_7FFF_FFFF);
    localparam logic [CW-1:0] NEG_MAX = CW'(33'h0_8000_0000);
    localparam logic [CW-1:0] U_MAX   = CW'(33'h0_FFFF_FFFF);

    // Truncated quotient magnitude to saturated two's complement
    function automatic logic [OUT_W-1:0] sat_signed(input logic [NW-1:0] mag_in,
                                                    input logic neg);
        logic [CW-1:0] m;
        logic [CW-1:0] m_neg;
        begin
            m     = CW'(mag_in);
            m_neg = -m;
            if (neg) begin
                sat_signed = (m > NEG_MAX) ? NEG_MAX[OUT_W-1:0] : m_neg[OUT_W-1:0];
            end else begin
                sat_signed = (m > POS_MAX) ? POS_MAX[OUT_W-1:0] : m[OUT_W-1:0];
            end
        end
    endfunction

    function automatic logic [OUT_W-1:0] sat_unsigned(input logic [NW-1:0] mag_in);
        logic [CW-1:0] m;
        begin
            m            = CW'(mag_in);
            sat_unsigned = (m > U_MAX) ? U_MAX[OUT_W-1:0] : m[OUT_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Flow control: everything advances unless the output beat is stuck
    // ------------------------------------------------------------------
    logic             adv;
    logic [FRONT-1:0] vld_reg;
    logic             m_valid_reg;

    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[FRONT-2:0], s_axis_tvalid};
        end
    end

    // Unpack the input beat
    logic signed [W-1:0] in_x0, in_y0, in_x1, in_y1, in_x2, in_y2;

    assign in_x0 = s_axis_tdata[0*W +: W];
    assign in_y0 = s_axis_tdata[1*W +: W];
    assign in_x1 = s_axis_tdata[2*W +: W];
    assign in_y1 = s_axis_tdata[3*W +: W];
    assign in_x2 = s_axis_tdata[4*W +: W];
    assign in_y2 = s_axis_tdata[5*W +: W];

    // ------------------------------------------------------------------
    // Stage 1: edge vectors relative to the first vertex
    // ------------------------------------------------------------------
    logic signed [W-1:0]  st1_x0_reg, st1_y0_reg;
    logic signed [DW-1:0] st1_dx1_reg, st1_dy1_reg, st1_dx2_reg, st1_dy2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_x0_reg  <= in_x0;
            st1_y0_reg  <= in_y0;
            st1_dx1_reg <= DW'(in_x1) - DW'(in_x0);
            st1_dy1_reg <= DW'(in_y1) - DW'(in_y0);
            st1_dx2_reg <= DW'(in_x2) - DW'(in_x0);
            st1_dy2_reg <= DW'(in_y2) - DW'(in_y0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares and cross products of the edges
    // ------------------------------------------------------------------
    logic        [SQW-1:0] st2_sx1_reg, st2_sy1_reg, st2_sx2_reg, st2_sy2_reg;
    logic signed [PXW-1:0] st2_p_reg, st2_q_reg;
    logic signed [W-1:0]   st2_x0_reg, st2_y0_reg;
    logic signed [DW-1:0]  st2_dx1_reg, st2_dy1_reg, st2_dx2_reg, st2_dy2_reg;
    logic signed [PXW-1:0] sx1_full, sy1_full, sx2_full, sy2_full;

    always_comb begin
        sx1_full = PXW'(st1_dx1_reg) * PXW'(st1_dx1_reg);
        sy1_full = PXW'(st1_dy1_reg) * PXW'(st1_dy1_reg);
        sx2_full = PXW'(st1_dx2_reg) * PXW'(st1_dx2_reg);
        sy2_full = PXW'(st1_dy2_reg) * PXW'(st1_dy2_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st2_sx1_reg <= sx1_full[SQW-1:0];
            st2_sy1_reg <= sy1_full[SQW-1:0];
            st2_sx2_reg <= sx2_full[SQW-1:0];
            st2_sy2_reg <= sy2_full[SQW-1:0];
            st2_p_reg   <= PXW'(st1_dx1_reg) * PXW'(st1_dy2_reg);
            st2_q_reg   <= PXW'(st1_dx2_reg) * PXW'(st1_dy1_reg);
            st2_x0_reg  <= st1_x0_reg;
            st2_y0_reg  <= st1_y0_reg;
            st2_dx1_reg <= st1_dx1_reg;
            st2_dy1_reg <= st1_dy1_reg;
            st2_dx2_reg <= st1_dx2_reg;
            st2_dy2_reg <= st1_dy2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared edge lengths and the determinant
    // ------------------------------------------------------------------
    logic        [SW-1:0] st3_s1_reg, st3_s2_reg;
    logic signed [AW-1:0] st3_a_reg;
    logic signed [W-1:0]  st3_x0_reg, st3_y0_reg;
    logic signed [DW-1:0] st3_dx1_reg, st3_dy1_reg, st3_dx2_reg, st3_dy2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st3_s1_reg  <= SW'(st2_sx1_reg) + SW'(st2_sy1_reg);
            st3_s2_reg  <= SW'(st2_sx2_reg) + SW'(st2_sy2_reg);
            st3_a_reg   <= AW'(st2_p_reg) - AW'(st2_q_reg);
            st3_x0_reg  <= st2_x0_reg;
            st3_y0_reg  <= st2_y0_reg;
            st3_dx1_reg <= st2_dx1_reg;
            st3_dy1_reg <= st2_dy1_reg;
            st3_dx2_reg <= st2_dx2_reg;
            st3_dy2_reg <= st2_dy2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: numerator products and 2a times the first vertex
    // ------------------------------------------------------------------
    logic signed [TAW-1:0] ta3;
    logic signed [SW:0]    s1_sgn, s2_sgn;
    logic signed [PW-1:0]  st4_m1_reg, st4_m2_reg, st4_m3_reg, st4_m4_reg;
    logic signed [TXW-1:0] st4_tax_reg, st4_tay_reg;
    logic signed [TAW-1:0] st4_ta_reg;

    assign ta3    = {st3_a_reg, 1'b0};
    assign s1_sgn = {1'b0, st3_s1_reg};
    assign s2_sgn = {1'b0, st3_s2_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            st4_m1_reg  <= PW'(s1_sgn) * PW'(st3_dy2_reg);
            st4_m2_reg  <= PW'(s2_sgn) * PW'(st3_dy1_reg);
            st4_m3_reg  <= PW'(s1_sgn) * PW'(st3_dx2_reg);
            st4_m4_reg  <= PW'(s2_sgn) * PW'(st3_dx1_reg);
            st4_tax_reg <= TXW'(ta3) * TXW'(st3_x0_reg);
            st4_tay_reg <= TXW'(ta3) * TXW'(st3_y0_reg);
            st4_ta_reg  <= ta3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: offsets of the center and absolute center numerators
    // ------------------------------------------------------------------
    logic signed [UW-1:0]  st5_ux_reg, st5_by_reg;
    logic signed [NW-1:0]  st5_nx_reg, st5_vy_reg;
    logic signed [TAW-1:0] st5_ta_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st5_ux_reg <= UW'(st4_m1_reg) - UW'(st4_m2_reg);
            st5_by_reg <= UW'(st4_m3_reg) - UW'(st4_m4_reg);
            st5_nx_reg <= NW'(st4_m1_reg) - NW'(st4_m2_reg) + NW'(st4_tax_reg);
            st5_vy_reg <= NW'(st4_tay_reg) - NW'(st4_m3_reg) + NW'(st4_m4_reg);
            st5_ta_reg <= st4_ta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: magnitudes, quotient signs and the collinear flag
    // ------------------------------------------------------------------
    logic signed [UW-1:0]  ux_abs, by_abs;
    logic signed [NW-1:0]  nx_abs, vy_abs;
    logic signed [TAW-1:0] ta_abs;
    logic                  cxn_next, cyn_next, degen_next;
    logic [SIDE_W-1:0]     side6_next;
    logic [MW-1:0]         st6_uxm_reg, st6_bym_reg;
    logic [SIDE_W-1:0]     st6_side_reg;

    always_comb begin
        ux_abs     = st5_ux_reg[UW-1] ? -st5_ux_reg : st5_ux_reg;
        by_abs     = st5_by_reg[UW-1] ? -st5_by_reg : st5_by_reg;
        nx_abs     = st5_nx_reg[NW-1] ? -st5_nx_reg : st5_nx_reg;
        vy_abs     = st5_vy_reg[NW-1] ? -st5_vy_reg : st5_vy_reg;
        ta_abs     = st5_ta_reg[TAW-1] ? -st5_ta_reg : st5_ta_reg;
        cxn_next   = st5_nx_reg[NW-1] ^ st5_ta_reg[TAW-1];
        cyn_next   = st5_vy_reg[NW-1] ^ st5_ta_reg[TAW-1];
        degen_next = (st5_ta_reg == '0);
        side6_next = {nx_abs, vy_abs, ta_abs[DEN_W-1:0], cxn_next, cyn_next, degen_next};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st6_uxm_reg  <= ux_abs[MW-1:0];
            st6_bym_reg  <= by_abs[MW-1:0];
            st6_side_reg <= side6_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: split squares into half-width partial products
    // ------------------------------------------------------------------
    logic [HI-1:0]     ux_hi, by_hi;
    logic [LO-1:0]     ux_lo, by_lo;
    logic [HH-1:0]     st7_uhh_reg, st7_bhh_reg;
    logic [HL-1:0]     st7_uhl_reg, st7_bhl_reg;
    logic [LL-1:0]     st7_ull_reg, st7_bll_reg;
    logic [SIDE_W-1:0] st7_side_reg;

    assign ux_hi = st6_uxm_reg[MW-1 -: HI];
    assign ux_lo = st6_uxm_reg[LO-1:0];
    assign by_hi = st6_bym_reg[MW-1 -: HI];
    assign by_lo = st6_bym_reg[LO-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            st7_uhh_reg  <= HH'(ux_hi) * HH'(ux_hi);
            st7_uhl_reg  <= HL'(ux_hi) * HL'(ux_lo);
            st7_ull_reg  <= LL'(ux_lo) * LL'(ux_lo);
            st7_bhh_reg  <= HH'(by_hi) * HH'(by_hi);
            st7_bhl_reg  <= HL'(by_hi) * HL'(by_lo);
            st7_bll_reg  <= LL'(by_lo) * LL'(by_lo);
            st7_side_reg <= st6_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: assemble each square; stage 9: sum into the radicand
    // ------------------------------------------------------------------
    logic [QW-1:0]     st8_usq_reg, st8_bsq_reg;
    logic [SIDE_W-1:0] st8_side_reg;
    logic [QW-1:0]     st9_rad_reg;
    logic [SIDE_W-1:0] st9_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st8_usq_reg  <= (QW'(st7_uhh_reg) << LL) + (QW'(st7_uhl_reg) << (LO + 1))
                            + QW'(st7_ull_reg);
            st8_bsq_reg  <= (QW'(st7_bhh_reg) << LL) + (QW'(st7_bhl_reg) << (LO + 1))
                            + QW'(st7_bll_reg);
            st8_side_reg <= st7_side_reg;
            st9_rad_reg  <= st8_usq_reg + st8_bsq_reg;
            st9_side_reg <= st8_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the scaled squared radius
    // ------------------------------------------------------------------
    tcc_pkg::step_t    sq_ctl;
    logic              sq_valid;
    logic [MW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    assign sq_ctl.adv = adv;
    assign sq_ctl.vld = vld_reg[FRONT-1];

    tcc_sqrt #(
        .ROOT_W (MW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (sq_ctl),
        .rad       (st9_rad_reg),
        .side_in   (st9_side_reg),
        .valid_out (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ------------------------------------------------------------------
    // Divide both center numerators and the root by |2a|
    // ------------------------------------------------------------------
    tcc_pkg::step_t        dv_ctl;
    logic [2:0][NW-1:0]    dv_num;
    logic                  dv_valid;
    logic [2:0][NW-1:0]    dv_quo;
    logic [FLAG_W-1:0]     dv_flags;

    assign dv_ctl.adv = adv;
    assign dv_ctl.vld = sq_valid;
    assign dv_num[0]  = sq_side[FLAG_W + DEN_W + NW +: NW];
    assign dv_num[1]  = sq_side[FLAG_W + DEN_W +: NW];
    assign dv_num[2]  = NW'(sq_root);

    tcc_div #(
        .NUM_W  (NW),
        .DEN_W  (DEN_W),
        .LANES  (3),
        .SIDE_W (FLAG_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (dv_ctl),
        .num       (dv_num),
        .den       (sq_side[FLAG_W +: DEN_W]),
        .side_in   (sq_side[FLAG_W-1:0]),
        .valid_out (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_flags)
    );

    // ------------------------------------------------------------------
    // Output register: saturate, zero a degenerate triangle, hold on stall
    // ------------------------------------------------------------------
    logic [OUT_W-1:0]             cx_next, cy_next, rad_next;
    logic [tcc_pkg::M_DATA_W-1:0] m_tdata_next;
    logic [tcc_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                         m_tuser_reg;

    always_comb begin
        cx_next  = sat_signed(dv_quo[0], dv_flags[2]);
        cy_next  = sat_signed(dv_quo[1], dv_flags[1]);
        rad_next = sat_unsigned(dv_quo[2]);
        if (dv_flags[0]) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {rad_next, cy_next, cx_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= dv_flags[0];
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_tdata_reg;
    assign m_axis_tuser[0] = m_tuser_reg;

    // Degenerate results carry all-zero data
    `ASSERT_CLK(a_degen_zero, aclk, aresetn,
        m_valid_reg && m_tuser_reg |-> m_tdata_reg == '0,
        "degenerate result with nonzero data")

    // A held output freezes the front of the pipeline
    `ASSERT_CLK(a_stall_freeze, aclk, aresetn,
        !adv |=> $stable(vld_reg),
        "pipeline moved during output stall")

    // Leaving reset, no result is presented
    `ASSERT_ALWAYS(a_reset_empty, aclk,
        $rose(aresetn) |-> !m_valid_reg,
        "output valid right after reset")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams triangles into triangle_circumcircle and checks each result beat
// against a typed table answer or an exact-integer circumcircle predictor. A directed
// table comes first, then random triangles with random idling on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int CW        = 16;
    localparam int S_DATA_W  = 96;
    localparam int N_RANDOM  = 600;
    localparam int N_CALM    = 100;
    localparam int DRAIN_CYC = 250;

    typedef struct {
        logic signed [CW-1:0] vx [3];
        logic signed [CW-1:0] vy [3];
    } shape_t;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [31:0]        radius;
        logic               degenerate;
    } disc_t;

    typedef struct {
        shape_t shape;
        logic   typed;
        disc_t  want;
    } row_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [S_DATA_W-1:0]                 s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [tcc_pkg::M_DATA_W-1:0]        m_axis_tdata;
    logic [0:0]                          m_axis_tuser;

    disc_t     pending_circles [$];
    int        fail_count;
    bit        calm;
    logic      cur_typed;
    disc_t     cur_want;
    shape_t    cur_tri;

    triangle_circumcircle #(.COORD_WIDTH(CW)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Generate the clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Clamp a wide signed quotient to 32 bits
    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [127:0] dist_sq(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return 128'(dx * dx) + 128'(dy * dy);
    endfunction

    // Circumcenter quotients truncated toward zero, and floor of circumradius
    function automatic disc_t circumcircle(shape_t t);
        longint   x [3];
        longint   y [3];
        longint   r [3];
        longint   det;
        longint   nx;
        longint   ny;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] root;
        disc_t    c;
        for (int i = 0; i < 3; i++) begin
            x[i] = longint'(t.vx[i]);
            y[i] = longint'(t.vy[i]);
            r[i] = x[i] * x[i] + y[i] * y[i];
        end
        det = x[0]*y[1] - x[1]*y[0] - x[0]*y[2] + x[2]*y[0] + x[1]*y[2] - x[2]*y[1];
        if (det == 0) begin
            c.cx = '0;
            c.cy = '0;
            c.radius = '0;
            c.degenerate = 1'b1;
            return c;
        end
        nx = r[0]*y[1] - r[1]*y[0] - r[0]*y[2] + r[2]*y[0] + r[1]*y[2] - r[2]*y[1];
        ny = r[0]*x[1] - r[1]*x[0] - r[0]*x[2] + r[2]*x[0] + r[1]*x[2] - r[2]*x[1];
        c.cx = clamp32(nx / (2 * det));
        c.cy = clamp32((-ny) / (2 * det));
        num = dist_sq(x[0], y[0], x[1], y[1]) * dist_sq(x[1], y[1], x[2], y[2])
            * dist_sq(x[2], y[2], x[0], y[0]);
        den = 128'(2 * det) * 128'(2 * det);
        if (det < 0) den = 128'(-2 * det) * 128'(-2 * det);
        q = num / den;
        if (q[127:64] != 0) begin
            c.radius = 32'hFFFFFFFF;
        end else begin
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                if (((root | (128'd1 << b)) * (root | (128'd1 << b))) <= q)
                    root = root | (128'd1 << b);
            end
            c.radius = root[31:0];
        end
        c.degenerate = 1'b0;
        return c;
    endfunction

    function automatic shape_t make_tri(int x0, int y0, int x1, int y1, int x2, int y2);
        shape_t t;
        t.vx[0] = CW'(x0); t.vy[0] = CW'(y0);
        t.vx[1] = CW'(x1); t.vy[1] = CW'(y1);
        t.vx[2] = CW'(x2); t.vy[2] = CW'(y2);
        return t;
    endfunction

    function automatic logic [15:0] rand_coord(int span);
        if (span >= 32768) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    // Random triangle: general, small, nearly or exactly collinear
    function automatic shape_t rand_tri();
        shape_t t;
        int kind;
        int span;
        int k;
        kind = $urandom_range(9);
        span = (kind < 4) ? 32768 : (kind < 7) ? 300 : 4000;
        for (int i = 0; i < 3; i++) begin
            t.vx[i] = rand_coord(span);
            t.vy[i] = rand_coord(span);
        end
        if (kind >= 7) begin
            k = $urandom_range(6) - 3;
            t.vx[2] = CW'(t.vx[0] + k * (t.vx[1] - t.vx[0])
                          + ((kind == 9) ? $urandom_range(2) - 1 : 0));
            t.vy[2] = CW'(t.vy[0] + k * (t.vy[1] - t.vy[0]));
        end
        return t;
    endfunction

    // Track accepted triangles and check result beats
    always @(posedge aclk) begin
        disc_t want;
        if (aresetn && s_axis_tvalid && s_axis_tready)
            pending_circles.push_back(cur_typed ? cur_want : circumcircle(cur_tri));
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_circles.size() == 0) begin
                $error("result beat with nothing pending");
                fail_count++;
            end else begin
                want = pending_circles.pop_front();
                if (m_axis_tdata[31:0] !== want.cx) begin
                    $error("center_x expected %0d got %0d", want.cx,
                           $signed(m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (m_axis_tdata[63:32] !== want.cy) begin
                    $error("center_y expected %0d got %0d", want.cy,
                           $signed(m_axis_tdata[63:32]));
                    fail_count++;
                end
                if (m_axis_tdata[95:64] !== want.radius) begin
                    $error("radius expected %0d got %0d", want.radius, m_axis_tdata[95:64]);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== want.degenerate) begin
                    $error("degenerate expected %0d got %0d", want.degenerate, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Stall the result side in random bursts
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (!calm && $urandom_range(3) == 0) begin
                hold = $urandom_range(16, 1) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
            if (hold > 0) m_axis_tready = 1'b0;
        end
    end

    // Present one triangle and hold it until accepted
    task automatic send_triangle(shape_t t, logic typed, disc_t want);
        int gap;
        if (!calm && $urandom_range(3) == 0) begin
            gap = $urandom_range(16, 1);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        cur_tri = t;
        cur_typed = typed;
        cur_want = want;
        s_axis_tdata = {t.vy[2], t.vx[2], t.vy[1], t.vx[1], t.vy[0], t.vx[0]};
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Walk the directed table, pause, then run random triangles
    initial begin
        row_t    rows [$];
        row_t    row;
        disc_t   none;
        fail_count = 0;
        calm = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cur_typed = 1'b0;
        none = '{cx: 0, cy: 0, radius: 0, degenerate: 1'b1};

        // Degenerate triangles and simple right triangles have an obvious answer
        rows.push_back('{make_tri(0, 0, 0, 0, 0, 0), 1'b1, none});
        rows.push_back('{make_tri(-32768, -32768, -32768, -32768, 32767, 32767), 1'b1, none});
        rows.push_back('{make_tri(-32768, -32768, 0, 0, 32767, 32767), 1'b0, none});
        rows.push_back('{make_tri(-32768, 0, 0, 0, 32767, 0), 1'b1, none});
        rows.push_back('{make_tri(5, -32768, 5, 100, 5, 32767), 1'b1, none});
        rows.push_back('{make_tri(0, 0, 2, 0, 0, 2), 1'b1,
                         '{cx: 1, cy: 1, radius: 1, degenerate: 1'b0}});
        rows.push_back('{make_tri(0, 0, 512, 0, 0, 512), 1'b1,
                         '{cx: 256, cy: 256, radius: 362, degenerate: 1'b0}});
        // Extremes, saturation and sign combinations
        rows.push_back('{make_tri(-32768, -32768, 32767, -32768, -32768, 32767), 1'b0, none});
        rows.push_back('{make_tri(32767, 32767, -32768, 32767, 32767, -32768), 1'b0, none});
        rows.push_back('{make_tri(-32768, -32768, 32767, 32767, 32767, 32766), 1'b0, none});
        rows.push_back('{make_tri(-32768, -32768, 32767, 32767, 32766, 32767), 1'b0, none});
        rows.push_back('{make_tri(32767, -32768, -32768, 32767, -32767, 32767), 1'b0, none});
        rows.push_back('{make_tri(0, 0, 1, 0, 32767, 1), 1'b0, none});
        rows.push_back('{make_tri(0, 0, -1, 0, -32768, -1), 1'b0, none});
        rows.push_back('{make_tri(-1, -1, 1, -1, 0, 1), 1'b0, none});
        rows.push_back('{make_tri(3, 7, -5, 2, 9, -4), 1'b0, none});
        rows.push_back('{make_tri(-32768, 0, 32767, 0, 0, 1), 1'b0, none});

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            row = rows[i];
            send_triangle(row.shape, row.typed, row.want);
        end

        // Hold off until the pipeline has drained
        s_axis_tvalid = 1'b0;
        while (pending_circles.size() != 0) @(negedge aclk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_CALM) calm = 1'b1;
            send_triangle(rand_tri(), 1'b0, none);
        end
        s_axis_tvalid = 1'b0;

        while (pending_circles.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS triangle_circumcircle");
        end else begin
            $display("FAIL triangle_circumcircle");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #5ms;
        $display("FAIL triangle_circumcircle");
        $finish;
    end

endmodule
